>>> hw/rtl/iep_pkg.sv
// Shared types and constants for the edge-replicating border padder.
// Used by iep_ctrl, iep_dp and image_edge_replicate_padder_core.
`timescale 1ns / 1ps

package iep_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_MARGIN = 15;
  localparam int DEF_PIXEL_BITS = 32;

  // Fixed field widths
  localparam int COORD_BITS     = 13;
  localparam int SIZE_BITS      = 13;
  localparam int MARGIN_BITS    = 4;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int PIX_FIELD_BITS = 32;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MARGIN       = 2'd2;

  // Sequencer phases, also the datapath's coordinate select
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_OWN   = 3'd1;
  localparam logic [2:0] PH_LEFT  = 3'd2;
  localparam logic [2:0] PH_RIGHT = 3'd3;
  localparam logic [2:0] PH_TOP   = 3'd4;
  localparam logic [2:0] PH_BOT   = 3'd5;

  typedef struct packed {
    logic [2:0] phase;    // phase of the write being loaded
    logic       accept;   // capture a new item
    logic       load;     // load the output register
    logic       last;     // loaded write is the item's final one
    logic       idx_clr;
    logic       idx_inc;
  } iep_cmd_t;

  typedef struct packed {
    logic left;    // item sits in the first column
    logic right;   // item sits in the last column
    logic top;     // item sits in the first row
    logic bot;     // item sits in the last row
    logic m_zero;  // no border
    logic i_last;  // margin index at its final value
  } iep_sts_t;

endpackage

>>> hw/rtl/iep_dp.sv
// Datapath: configuration registers, raster position, held item, margin index
// and output register. Depends on iep_pkg.
`timescale 1ns / 1ps

module iep_dp #(
  parameter int MAX_WIDTH  = iep_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = iep_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_MARGIN = iep_pkg::DEF_MAX_MARGIN,
  parameter int PIXEL_BITS = iep_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [iep_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [iep_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [PIXEL_BITS-1:0]             pixel_in,
  input  iep_pkg::iep_cmd_t                 cmd,
  output iep_pkg::iep_sts_t                 sts,
  output logic [iep_pkg::COORD_BITS-1:0]    dest_row,
  output logic [iep_pkg::COORD_BITS-1:0]    dest_col,
  output logic [PIXEL_BITS-1:0]             pixel_out,
  output logic                              last_write
);
  import iep_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int QW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MW = (MAX_MARGIN > 0) ? $clog2(MAX_MARGIN + 1) : 1;
  localparam int FB = (PIXEL_BITS < PIX_FIELD_BITS) ? PIXEL_BITS : PIX_FIELD_BITS;

  logic [SIZE_BITS-1:0]   image_width;
  logic [SIZE_BITS-1:0]   image_height;
  logic [MARGIN_BITS-1:0] margin;

  logic [PW-1:0] column_pos;
  logic [QW-1:0] row_pos;

  logic [PW-1:0]         c_hold;
  logic [QW-1:0]         r_hold;
  logic [PIXEL_BITS-1:0] pix_hold;
  logic                  left, right, top, bot;
  logic [MW-1:0]         idx;

  logic [WW-1:0]         w;
  logic [HW-1:0]         h;
  logic [MW-1:0]         m;
  logic [PW-1:0]         c;
  logic [QW-1:0]         r;
  logic                  c_first, c_last, r_first, r_last;
  logic [PIXEL_BITS-1:0] pix_in_m;
  logic [31:0]           rm, cm;
  logic [COORD_BITS-1:0] row_sel, col_sel;

  // Effective sizes: zero reads as one, oversize saturates
  always_comb begin
    if (image_width == '0) begin
      w = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width);
    end
    if (image_height == '0) begin
      h = HW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(image_height);
    end
    if (32'(margin) > 32'(MAX_MARGIN)) begin
      m = MW'(MAX_MARGIN);
    end else begin
      m = MW'(margin);
    end
  end

  // Position left beyond a shrunk size counts as the last column / row
  always_comb begin
    c = (32'(column_pos) >= 32'(w)) ? PW'(32'(w) - 32'd1) : column_pos;
    r = (32'(row_pos) >= 32'(h)) ? QW'(32'(h) - 32'd1) : row_pos;
    c_first = (c == '0);
    c_last  = (32'(c) + 32'd1 == 32'(w));
    r_first = (r == '0);
    r_last  = (32'(r) + 32'd1 == 32'(h));
    pix_in_m = '0;
    pix_in_m[FB-1:0] = pixel_in[FB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_BITS'(1);
      image_height <= SIZE_BITS'(1);
      margin       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_MARGIN:       margin       <= cfg_data[MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (cmd.accept) begin
      if (c_last) begin
        column_pos <= '0;
        row_pos    <= r_last ? '0 : QW'(32'(r) + 32'd1);
      end else begin
        column_pos <= PW'(32'(c) + 32'd1);
        row_pos    <= r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c_hold   <= c;
      r_hold   <= r;
      pix_hold <= pix_in_m;
      left     <= c_first;
      right    <= c_last;
      top      <= r_first;
      bot      <= r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= MW'(32'(idx) + 32'd1);
    end
  end

  assign sts.left   = left;
  assign sts.right  = right;
  assign sts.top    = top;
  assign sts.bot    = bot;
  assign sts.m_zero = (m == '0);
  assign sts.i_last = (32'(idx) + 32'd1 == 32'(m));

  // Coordinate select per phase
  always_comb begin
    rm = 32'(r_hold) + 32'(m);
    cm = 32'(c_hold) + 32'(m);
    case (cmd.phase)
      PH_LEFT: begin
        row_sel = COORD_BITS'(rm);
        col_sel = COORD_BITS'(idx);
      end
      PH_RIGHT: begin
        row_sel = COORD_BITS'(rm);
        col_sel = COORD_BITS'(32'(w) + 32'(m) + 32'(idx));
      end
      PH_TOP: begin
        row_sel = COORD_BITS'(idx);
        col_sel = COORD_BITS'(cm);
      end
      PH_BOT: begin
        row_sel = COORD_BITS'(32'(h) + 32'(m) + 32'(idx));
        col_sel = COORD_BITS'(cm);
      end
      default: begin
        row_sel = COORD_BITS'(rm);
        col_sel = COORD_BITS'(cm);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dest_row   <= row_sel;
      dest_col   <= col_sel;
      pixel_out  <= pix_hold;
      last_write <= cmd.last;
    end
  end

endmodule

>>> hw/rtl/iep_ctrl.sv
// Write sequencer: steps own position, left, right, top and bottom margins,
// and owns both handshakes. Depends on iep_pkg.
`timescale 1ns / 1ps

module iep_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  output logic              dst_valid,
  input  logic              dst_stall,
  input  iep_pkg::iep_sts_t sts,
  output iep_pkg::iep_cmd_t cmd
);
  import iep_pkg::*;

  logic [2:0] state, state_next;
  logic [2:0] nxt;
  logic       has_l, has_r, has_t, has_b;
  logic       phase_done, step, cur_last, accept;

  always_comb begin
    has_l = sts.left  & ~sts.m_zero;
    has_r = sts.right & ~sts.m_zero;
    has_t = sts.top   & ~sts.m_zero;
    has_b = sts.bot   & ~sts.m_zero;

    // phase that follows the current one
    case (state)
      PH_OWN:   nxt = has_l ? PH_LEFT : has_r ? PH_RIGHT : has_t ? PH_TOP :
                      has_b ? PH_BOT : PH_IDLE;
      PH_LEFT:  nxt = has_r ? PH_RIGHT : has_t ? PH_TOP : has_b ? PH_BOT : PH_IDLE;
      PH_RIGHT: nxt = has_t ? PH_TOP : has_b ? PH_BOT : PH_IDLE;
      PH_TOP:   nxt = has_b ? PH_BOT : PH_IDLE;
      default:  nxt = PH_IDLE;
    endcase

    phase_done = (state == PH_OWN) || sts.i_last;
    step       = (state != PH_IDLE) && (!dst_valid || !dst_stall);
    cur_last   = phase_done && (nxt == PH_IDLE);
    // next item enters on the edge that loads this one's last write
    src_stall  = !((state == PH_IDLE) || (step && cur_last));
    accept     = src_valid && !src_stall;

    state_next = state;
    if (state == PH_IDLE) begin
      if (accept) state_next = PH_OWN;
    end else if (step && phase_done) begin
      if (nxt == PH_IDLE) begin
        state_next = accept ? PH_OWN : PH_IDLE;
      end else begin
        state_next = nxt;
      end
    end

    cmd.phase   = state;
    cmd.accept  = accept;
    cmd.load    = step;
    cmd.last    = cur_last;
    cmd.idx_clr = step && phase_done;
    cmd.idx_inc = step && !phase_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_IDLE;
      dst_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step) begin
        dst_valid <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/image_edge_replicate_padder_core.sv
// Top level of the edge-replicating border padder.
// Instantiates iep_ctrl and iep_dp; depends on iep_pkg.
`timescale 1ns / 1ps

// Takes source pixels in raster order and issues writes into an image padded
// by "margin" pixels on every side: each pixel goes to its shifted position,
// first/last column pixels are copied across the left/right margins, and
// first/last row pixels down the top/bottom margins; corners stay unwritten.
// Each result item is one write, and the write sequencer issues one per clock
// while the sink does not stall; a pixel causes one write if interior and up
// to 1 + 4*margin at a single-pixel image. The next item is taken on the same
// edge that loads the previous item's last write, so a run of interior pixels
// flows at one item per cycle when the sink does not stall.
// Configuration writes take effect immediately and do not reset the position.

module image_edge_replicate_padder_core #(
  parameter int MAX_WIDTH  = iep_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = iep_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_MARGIN = iep_pkg::DEF_MAX_MARGIN,
  parameter int PIXEL_BITS = iep_pkg::DEF_PIXEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [iep_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [iep_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               src_valid,
  output logic                               src_stall,
  input  logic [PIXEL_BITS-1:0]              pixel_in,
  output logic                               dst_valid,
  input  logic                               dst_stall,
  output logic [iep_pkg::COORD_BITS-1:0]     dest_row,
  output logic [iep_pkg::COORD_BITS-1:0]     dest_col,
  output logic [PIXEL_BITS-1:0]              pixel_out,
  output logic                               last_write
);
  import iep_pkg::*;

  iep_cmd_t cmd;
  iep_sts_t sts;

  iep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  iep_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_MARGIN (MAX_MARGIN),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_in   (pixel_in),
    .cmd        (cmd),
    .sts        (sts),
    .dest_row   (dest_row),
    .dest_col   (dest_col),
    .pixel_out  (pixel_out),
    .last_write (last_write)
  );

endmodule

>>> tb/image_edge_replicate_padder_core_tb.sv
// Self-checking testbench for image_edge_replicate_padder_core.
// Predicts the padded-image writes of every accepted pixel and checks each write
// in order. Depends on iep_pkg and the padder RTL.
`timescale 1ns / 1ps

module image_edge_replicate_padder_core_tb;

  localparam int PIX_BITS = iep_pkg::DEF_PIXEL_BITS;
  localparam int CRD_BITS = iep_pkg::COORD_BITS;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [iep_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic [iep_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [iep_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                               src_valid = 1'b0;
  logic                               src_stall;
  logic [PIX_BITS-1:0]                pixel_in = '0;
  logic                               dst_valid;
  logic                               dst_stall = 1'b0;
  logic [CRD_BITS-1:0]                dest_row;
  logic [CRD_BITS-1:0]                dest_col;
  logic [PIX_BITS-1:0]                pixel_out;
  logic                               last_write;

  logic steady = 1'b0;  // no idling on either side while set

  image_edge_replicate_padder_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .pixel_in   (pixel_in),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .dest_row   (dest_row),
    .dest_col   (dest_col),
    .pixel_out  (pixel_out),
    .last_write (last_write)
  );

  typedef struct packed {
    logic [CRD_BITS-1:0] row;
    logic [CRD_BITS-1:0] col;
    logic [PIX_BITS-1:0] pix;
    logic                last;
  } pad_write_t;

  class padder_scoreboard;
    pad_write_t                        expected_writes[$];
    int unsigned                       mismatches;
    logic [iep_pkg::SIZE_BITS-1:0]     img_width;
    logic [iep_pkg::SIZE_BITS-1:0]     img_height;
    logic [iep_pkg::MARGIN_BITS-1:0]   border;
    int unsigned                       col_pos;
    int unsigned                       row_pos;

    function new();
      mismatches = 0;
      img_width  = 1;
      img_height = 1;
      border     = 0;
      col_pos    = 0;
      row_pos    = 0;
    endfunction

    function void write_reg(logic [iep_pkg::CFG_INDEX_BITS-1:0] idx,
                            logic [iep_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        iep_pkg::REG_IMAGE_WIDTH:  img_width  = data;
        iep_pkg::REG_IMAGE_HEIGHT: img_height = data;
        iep_pkg::REG_MARGIN:       border     = data[iep_pkg::MARGIN_BITS-1:0];
        default: ;
      endcase
    endfunction

    // zero counts as one, oversize saturates
    function int unsigned eff_width();
      if (img_width == 0) return 1;
      if (img_width > iep_pkg::DEF_MAX_WIDTH) return iep_pkg::DEF_MAX_WIDTH;
      return img_width;
    endfunction

    function int unsigned eff_height();
      if (img_height == 0) return 1;
      if (img_height > iep_pkg::DEF_MAX_HEIGHT) return iep_pkg::DEF_MAX_HEIGHT;
      return img_height;
    endfunction

    function void queue_write(int unsigned r, int unsigned c, logic [PIX_BITS-1:0] pix);
      pad_write_t wr;
      wr.row  = CRD_BITS'(r);
      wr.col  = CRD_BITS'(c);
      wr.pix  = pix;
      wr.last = 1'b0;
      expected_writes = {expected_writes, wr};
    endfunction

    function void note_pixel(logic [PIX_BITS-1:0] pix);
      int unsigned w, h, m, c, r, i;
      w = eff_width();
      h = eff_height();
      m = (border > iep_pkg::DEF_MAX_MARGIN) ? iep_pkg::DEF_MAX_MARGIN : border;
      // a position left past a shrunk size is taken as the last column/row
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      queue_write(r + m, c + m, pix);
      if (c == 0)     for (i = 0; i < m; i++) queue_write(r + m, i, pix);
      if (c == w - 1) for (i = 0; i < m; i++) queue_write(r + m, w + m + i, pix);
      if (r == 0)     for (i = 0; i < m; i++) queue_write(i, c + m, pix);
      if (r == h - 1) for (i = 0; i < m; i++) queue_write(h + m + i, c + m, pix);
      expected_writes[expected_writes.size() - 1].last = 1'b1;
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void check_write(pad_write_t got);
      pad_write_t exp_w;
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected write row=%0d col=%0d pix=%h last=%b",
                   $realtime, got.row, got.col, got.pix, got.last);
        return;
      end
      exp_w = expected_writes.pop_front();
      if (got.row !== exp_w.row || got.col !== exp_w.col ||
          got.pix !== exp_w.pix || got.last !== exp_w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp %0d/%0d %h %b, got %0d/%0d %h %b",
                   $realtime, exp_w.row, exp_w.col, exp_w.pix, exp_w.last,
                   got.row, got.col, got.pix, got.last);
      end
    endfunction

    function int unsigned pending();
      return expected_writes.size();
    endfunction
  endclass

  padder_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("image_edge_replicate_padder_core test failed");
    $finish;
  end

  // write sink: random stall, check every accepted write
  always @(posedge clk) begin
    if (!rst && dst_valid && !dst_stall)
      sb.check_write({dest_row, dest_col, pixel_out, last_write});
    dst_stall <= steady ? 1'b0 : ($urandom_range(99) < 28);
  end

  task automatic program_reg(input logic [iep_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [iep_pkg::CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [PIX_BITS-1:0] pix);
    while (!steady && $urandom_range(99) < 28) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    pixel_in  <= pix;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    sb.note_pixel(pix);
  endtask

  // every pixel yields at least one write, so an empty queue means idle
  task automatic drain_writes();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [PIX_BITS-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [iep_pkg::SIZE_BITS-1:0] rand_size();
    case ($urandom_range(11))
      0:       return '0;
      1:       return 13'd4096;
      2:       return 13'($urandom_range(8191, 4097));
      3:       return 13'($urandom_range(64, 7));
      default: return 13'($urandom_range(6, 1));
    endcase
  endfunction

  function automatic logic [iep_pkg::CFG_DATA_BITS-1:0] rand_margin();
    logic [3:0] m;
    case ($urandom_range(3))
      0:       m = 4'd0;
      1:       m = 4'd15;
      default: m = 4'($urandom_range(15));
    endcase
    // upper data bits are don't-care for the margin register
    if ($urandom_range(3) == 0) return {9'($urandom()), m};
    return {9'd0, m};
  endfunction

  initial begin
    int unsigned sent, n, k, w, h;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: 1x1 image, no border
    send_pixel('0);
    send_pixel('1);
    src_valid <= 1'b0;
    drain_writes();

    // single pixel image with the widest border
    program_reg(iep_pkg::REG_MARGIN, 13'd15);
    send_pixel(32'hA5A5_5A5A);
    src_valid <= 1'b0;
    drain_writes();

    // zero sizes behave as one
    program_reg(iep_pkg::REG_IMAGE_WIDTH, 13'd0);
    program_reg(iep_pkg::REG_IMAGE_HEIGHT, 13'd0);
    program_reg(iep_pkg::REG_MARGIN, 13'd2);
    send_pixel(32'h8000_0001);
    send_pixel(32'h7FFF_FFFE);
    src_valid <= 1'b0;
    drain_writes();

    // full 3x2 image plus one wrapped pixel
    program_reg(iep_pkg::REG_IMAGE_WIDTH, 13'd3);
    program_reg(iep_pkg::REG_IMAGE_HEIGHT, 13'd2);
    program_reg(iep_pkg::REG_MARGIN, 13'd1);
    for (k = 0; k < 7; k++) send_pixel(rand_pixel());
    src_valid <= 1'b0;
    drain_writes();

    // resize mid-image, position carries over
    program_reg(iep_pkg::REG_IMAGE_WIDTH, 13'd4);
    program_reg(iep_pkg::REG_IMAGE_HEIGHT, 13'd4);
    program_reg(iep_pkg::REG_MARGIN, 13'd3);
    for (k = 0; k < 6; k++) send_pixel(rand_pixel());
    src_valid <= 1'b0;
    drain_writes();

    // shrink below the current position
    program_reg(iep_pkg::REG_IMAGE_WIDTH, 13'd2);
    program_reg(iep_pkg::REG_IMAGE_HEIGHT, 13'd1);
    for (k = 0; k < 2; k++) send_pixel(rand_pixel());
    src_valid <= 1'b0;
    drain_writes();

    // oversize width saturates, maximum height, write to the unused index
    program_reg(iep_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
    program_reg(iep_pkg::REG_IMAGE_HEIGHT, 13'd4096);
    program_reg(iep_pkg::REG_MARGIN, 13'h1FFF);
    program_reg(REG_UNUSED, 13'h1FFF);
    send_pixel('1);
    send_pixel('0);
    src_valid <= 1'b0;
    drain_writes();

    // random phases; config changes between them
    sent = 0;
    while (sent < 160) begin
      drain_writes();
      if ($urandom_range(2) != 0) program_reg(iep_pkg::REG_IMAGE_WIDTH, rand_size());
      if ($urandom_range(2) != 0) program_reg(iep_pkg::REG_IMAGE_HEIGHT, rand_size());
      if ($urandom_range(2) != 0) program_reg(iep_pkg::REG_MARGIN, rand_margin());
      if ($urandom_range(15) == 0) program_reg(REG_UNUSED, 13'($urandom()));
      w = sb.eff_width();
      h = sb.eff_height();
      if (w * h <= 36 && $urandom_range(1) == 1) n = w * h;
      else n = $urandom_range(12, 1);
      for (k = 0; k < n; k++) begin
        steady <= (sent >= 60 && sent < 110);
        send_pixel(rand_pixel());
        sent++;
      end
      src_valid <= 1'b0;
    end
    steady <= 1'b0;

    drain_writes();
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("image_edge_replicate_padder_core test passed");
    else
      $display("image_edge_replicate_padder_core test failed");
    $finish;
  end

endmodule
